@@ design/mse_pkg.sv @@
package mse_pkg;

    localparam int MAX_ITEMS_DEF = 32;
    localparam int KEY_W         = 32;

    // Source bank select for the merge passes.
    localparam logic BANK_A = 1'b0;
    localparam logic BANK_B = 1'b1;

    typedef struct packed {
        logic load;         // store the accepted key of the current block
        logic sort_init;    // first merge pass, width one, source bank A
        logic run_setup;    // set up pointers for the next pair of runs
        logic merge_step;   // move one key from the source into the target bank
        logic out_init;     // point at the first sorted key
        logic out_step;     // advance to the next sorted key
        logic blk_clear;    // block delivered, clear count and drop flag
    } t_cmd;

    typedef struct packed {
        logic run_end;      // this merge step writes the final key of the run pair
        logic pass_end;     // the current run pair is the last one of the pass
        logic sort_done;    // run width covers the whole block
        logic out_last;     // current output key is the final one
    } t_sts;

endpackage

@@ design/mse_ctrl.sv @@
module mse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_last,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  mse_pkg::t_sts i_sts,
    output mse_pkg::t_cmd o_cmd
);
    import mse_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_SETUP = 4'b0010,
        S_MERGE = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   out_acc;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_acc     = o_out_valid & i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                o_cmd.load = in_acc;
                if (in_acc && i_last) begin
                    o_cmd.sort_init = 1'b1;
                    n_state         = S_SETUP;
                end
            end
            S_SETUP: begin
                if (i_sts.sort_done) begin
                    o_cmd.out_init = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    o_cmd.run_setup = 1'b1;
                    n_state         = S_MERGE;
                end
            end
            S_MERGE: begin
                o_cmd.merge_step = 1'b1;
                if (i_sts.run_end) begin
                    n_state = S_SETUP;
                end
            end
            S_OUT: begin
                o_cmd.out_step = out_acc;
                if (out_acc && i_sts.out_last) begin
                    o_cmd.blk_clear = 1'b1;
                    n_state         = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input and output channels open at the same time");

    a_last_in_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last) |=> !o_in_ready)
        else $error("input still open after the block ended");

    a_last_out_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_acc && i_sts.out_last) |=> o_in_ready)
        else $error("input not reopened after the final sorted item");
`endif

endmodule

@@ design/mse_dp.sv @@
module mse_dp #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mse_pkg::t_cmd                     i_cmd,
    input  logic signed [mse_pkg::KEY_W-1:0]  i_value,
    output mse_pkg::t_sts                     o_sts,
    output logic signed [mse_pkg::KEY_W-1:0]  o_value_res,
    output logic                              o_last_res,
    output logic                              o_overflow
);
    import mse_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SW = CW + 1;

    logic [KEY_W-1:0] mem_a [MAX_ITEMS];
    logic [KEY_W-1:0] mem_b [MAX_ITEMS];

    logic [KEY_W-1:0] r_rda_l, r_rda_r, r_rdb_l, r_rdb_r;

    logic [CW-1:0] r_cnt;
    logic          r_dropped;
    logic          r_src;
    logic [SW-1:0] r_w;
    logic [CW-1:0] r_lo, r_mid, r_hi;
    logic [CW-1:0] r_l, r_r, r_o;
    logic [CW-1:0] n_l, n_r;

    logic          full;
    logic [SW-1:0] cnt_ext, sum_mid, sum_hi;
    logic [CW-1:0] mid_c, hi_c;
    logic signed [KEY_W-1:0] dl, dr, dsel;
    logic          take_left;
    logic          we_a, we_b;
    logic [AW-1:0] wa_a;
    logic [KEY_W-1:0] wd_a;

    assign full    = (r_cnt == CW'(MAX_ITEMS));
    assign cnt_ext = SW'(r_cnt);
    assign sum_mid = SW'(r_lo) + r_w;
    assign sum_hi  = SW'(r_lo) + (r_w << 1);
    assign mid_c   = (sum_mid > cnt_ext) ? r_cnt : sum_mid[CW-1:0];
    assign hi_c    = (sum_hi > cnt_ext) ? r_cnt : sum_hi[CW-1:0];

    // Read data always belongs to the current l and r pointers.
    assign dl = (r_src == BANK_A) ? r_rda_l : r_rdb_l;
    assign dr = (r_src == BANK_A) ? r_rda_r : r_rdb_r;

    // Left run wins on ties, which keeps the sort stable.
    assign take_left = (r_l < r_mid) && ((r_r >= r_hi) || (dl <= dr));
    assign dsel      = take_left ? dl : dr;

    assign o_sts.run_end   = (r_o + CW'(1) == r_hi);
    assign o_sts.pass_end  = (sum_hi >= cnt_ext);
    assign o_sts.sort_done = (r_w >= cnt_ext);
    assign o_sts.out_last  = (r_l + CW'(1) == r_cnt);

    assign o_value_res = dl;
    assign o_last_res  = o_sts.out_last;
    assign o_overflow  = r_dropped;

    always_comb begin
        n_l = r_l;
        n_r = r_r;
        if (i_cmd.run_setup) begin
            n_l = r_lo;
            n_r = mid_c;
        end else if (i_cmd.merge_step) begin
            if (take_left) begin
                n_l = r_l + CW'(1);
            end else begin
                n_r = r_r + CW'(1);
            end
        end else if (i_cmd.out_init) begin
            n_l = '0;
        end else if (i_cmd.out_step) begin
            n_l = r_l + CW'(1);
        end
    end

    assign we_a = (i_cmd.load && !full) || (i_cmd.merge_step && r_src == BANK_B);
    assign we_b = i_cmd.merge_step && r_src == BANK_A;
    assign wa_a = i_cmd.load ? r_cnt[AW-1:0] : r_o[AW-1:0];
    assign wd_a = i_cmd.load ? i_value : dsel;

    always_ff @(posedge i_clk) begin
        if (we_a) begin
            mem_a[wa_a] <= wd_a;
        end
        r_rda_l <= mem_a[n_l[AW-1:0]];
        r_rda_r <= mem_a[n_r[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (we_b) begin
            mem_b[r_o[AW-1:0]] <= dsel;
        end
        r_rdb_l <= mem_b[n_l[AW-1:0]];
        r_rdb_r <= mem_b[n_r[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.blk_clear) begin
            r_cnt     <= '0;
            r_dropped <= 1'b0;
        end else if (i_cmd.load) begin
            if (full) begin
                r_dropped <= 1'b1;
            end else begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_l <= n_l;
        r_r <= n_r;
        if (i_cmd.sort_init) begin
            r_w   <= SW'(1);
            r_lo  <= '0;
            r_src <= BANK_A;
        end
        if (i_cmd.run_setup) begin
            r_mid <= mid_c;
            r_hi  <= hi_c;
            r_o   <= r_lo;
        end
        if (i_cmd.merge_step) begin
            r_o <= r_o + CW'(1);
            if (o_sts.run_end) begin
                if (o_sts.pass_end) begin
                    r_src <= ~r_src;
                    r_w   <= r_w << 1;
                    r_lo  <= '0;
                end else begin
                    r_lo <= sum_hi[CW-1:0];
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_merge_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_step |-> (r_o < r_hi))
        else $error("merge write beyond the end of the run pair");

    a_merge_has_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.merge_step |-> ((r_l < r_mid) || (r_r < r_hi)))
        else $error("merge step with both runs exhausted");

    a_out_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_step |-> (r_l < r_cnt))
        else $error("output index beyond the block");
`endif

endmodule

@@ design/merge_sort_engine.sv @@
// Channel   Handshake                  Payload
// input     i_in_valid / o_in_ready    i_value (Q16.16), i_last
// output    o_out_valid / i_out_ready  o_value_res (Q16.16), o_last_res, o_overflow
//
// Loaded items are stored in key memory A; the item marked last starts the sort.
// The sort runs bottom-up merge passes, one key per cycle through the two key
// memories, with a setup state before each run pair.
// Sorted items then leave at one per cycle while the output is ready; a new block is taken after the last.
// Reset is synchronous and active low and empties the block; no clearing pass.
// A stall on the output holds the current item; no input is taken meanwhile.
module merge_sort_engine #(
    parameter int MAX_ITEMS = mse_pkg::MAX_ITEMS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [mse_pkg::KEY_W-1:0]  i_value,
    input  logic                              i_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mse_pkg::KEY_W-1:0]  o_value_res,
    output logic                              o_last_res,
    output logic                              o_overflow
);
    import mse_pkg::*;

    t_cmd cmd;
    t_sts sts;

    mse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_last      (i_last),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    mse_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .o_sts       (sts),
        .o_value_res (o_value_res),
        .o_last_res  (o_last_res),
        .o_overflow  (o_overflow)
    );

endmodule
